// File: src/ubx_frame_parser_defines.svh
// Assertion macros shared by the UBX frame parser modules.
// No dependencies; included by every file that carries assertions.
`ifndef UBX_FRAME_PARSER_DEFINES_SVH
`define UBX_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UBX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UBX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/ubx_fp_pkg.sv
// Package for the UBX frame parser: parse phases, event codes, constants and structs.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ubx_fp_pkg;

  // Sync pattern that opens every frame.
  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CLASS  = 2'd0;
  localparam logic [1:0] CFG_ID     = 2'd1;
  localparam logic [1:0] CFG_LENGTH = 2'd2;

  // Configuration reset values.
  localparam logic [7:0]  RST_CLASS  = 8'd1;
  localparam logic [7:0]  RST_ID     = 8'd7;
  localparam logic [15:0] RST_LENGTH = 16'd92;

  // Parser phases.
  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN1    = 4'd4,
    PH_LEN2    = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CKA     = 4'd7,
    PH_CKB     = 4'd8
  } phase_t;

  // Frame event codes.
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_GOOD   = 2'd1,
    EV_CKERR  = 2'd2,
    EV_REJECT = 2'd3
  } frame_ev_t;

  // Active configuration values.
  typedef struct packed {
    logic [7:0]  expected_class;
    logic [7:0]  expected_id;
    logic [15:0] expected_length;
  } cfg_t;

  // One result transaction.
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_data;
    logic [15:0] payload_index;
    frame_ev_t   frame_event;
  } result_t;

endpackage

`default_nettype wire

// File: src/ubx_fp_cfg.sv
// Configuration registers of the UBX frame parser (class, id, length).
// Depends on ubx_fp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ubx_fp_cfg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_wdata,
  output ubx_fp_pkg::cfg_t       cfg
);

  ubx_fp_pkg::cfg_t cfg_r;
  ubx_fp_pkg::cfg_t cfg_nxt;

  // Decode the register write; unused indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        ubx_fp_pkg::CFG_CLASS:  cfg_nxt.expected_class  = cfg_wdata[7:0];
        ubx_fp_pkg::CFG_ID:     cfg_nxt.expected_id     = cfg_wdata[7:0];
        ubx_fp_pkg::CFG_LENGTH: cfg_nxt.expected_length = cfg_wdata;
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_class  <= ubx_fp_pkg::RST_CLASS;
      cfg_r.expected_id     <= ubx_fp_pkg::RST_ID;
      cfg_r.expected_length <= ubx_fp_pkg::RST_LENGTH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: src/ubx_fp_fsm.sv
// Frame state machine and Fletcher checksum of the UBX frame parser.
// Depends on ubx_fp_pkg and ubx_frame_parser_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "ubx_frame_parser_defines.svh"

module ubx_fp_fsm (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [7:0]        rx_byte,
  input  wire ubx_fp_pkg::cfg_t  cfg,
  output ubx_fp_pkg::result_t    res
);

  ubx_fp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [15:0] decl_len_r, decl_len_nxt;
  logic [15:0] byte_pos_r, byte_pos_nxt;

  // Checksum update for the current byte, and helpers for the length phases.
  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] full_len;
  logic [15:0] pos_inc;

  assign add_a    = sum_a_r + rx_byte;
  assign add_b    = sum_b_r + add_a;
  assign full_len = {rx_byte, decl_len_r[7:0]};
  assign pos_inc  = byte_pos_r + 16'd1;

  // Next-state logic.
  always_comb begin
    phase_nxt    = phase_r;
    sum_a_nxt    = sum_a_r;
    sum_b_nxt    = sum_b_r;
    decl_len_nxt = decl_len_r;
    byte_pos_nxt = byte_pos_r;
    case (phase_r)
      ubx_fp_pkg::PH_SYNC1: begin
        if (rx_byte == ubx_fp_pkg::SYNC_FIRST) phase_nxt = ubx_fp_pkg::PH_SYNC2;
      end
      ubx_fp_pkg::PH_SYNC2: begin
        phase_nxt = (rx_byte == ubx_fp_pkg::SYNC_SECOND) ? ubx_fp_pkg::PH_CLASS
                                                          : ubx_fp_pkg::PH_SYNC1;
      end
      ubx_fp_pkg::PH_CLASS: begin
        if (rx_byte != cfg.expected_class) begin
          phase_nxt = ubx_fp_pkg::PH_SYNC1;
        end else begin
          sum_a_nxt = rx_byte;
          sum_b_nxt = rx_byte;
          phase_nxt = ubx_fp_pkg::PH_ID;
        end
      end
      ubx_fp_pkg::PH_ID: begin
        if (rx_byte != cfg.expected_id) begin
          phase_nxt = ubx_fp_pkg::PH_SYNC1;
        end else begin
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          phase_nxt = ubx_fp_pkg::PH_LEN1;
        end
      end
      ubx_fp_pkg::PH_LEN1: begin
        decl_len_nxt = {8'd0, rx_byte};
        sum_a_nxt    = add_a;
        sum_b_nxt    = add_b;
        phase_nxt    = ubx_fp_pkg::PH_LEN2;
      end
      ubx_fp_pkg::PH_LEN2: begin
        decl_len_nxt = full_len;
        if (full_len != cfg.expected_length) begin
          phase_nxt = ubx_fp_pkg::PH_SYNC1;
        end else begin
          sum_a_nxt    = add_a;
          sum_b_nxt    = add_b;
          byte_pos_nxt = 16'd0;
          phase_nxt    = (full_len == 16'd0) ? ubx_fp_pkg::PH_CKA
                                             : ubx_fp_pkg::PH_PAYLOAD;
        end
      end
      ubx_fp_pkg::PH_PAYLOAD: begin
        sum_a_nxt    = add_a;
        sum_b_nxt    = add_b;
        byte_pos_nxt = pos_inc;
        if (pos_inc >= decl_len_r) phase_nxt = ubx_fp_pkg::PH_CKA;
      end
      ubx_fp_pkg::PH_CKA: begin
        phase_nxt = (rx_byte != sum_a_r) ? ubx_fp_pkg::PH_SYNC1 : ubx_fp_pkg::PH_CKB;
      end
      ubx_fp_pkg::PH_CKB: begin
        phase_nxt = ubx_fp_pkg::PH_SYNC1;
      end
      default: begin
        phase_nxt = ubx_fp_pkg::PH_SYNC1;
      end
    endcase
  end

  // Result for the byte being accepted.
  always_comb begin
    res               = '0;
    res.frame_event   = ubx_fp_pkg::EV_NONE;
    case (phase_r)
      ubx_fp_pkg::PH_CLASS: begin
        if (rx_byte != cfg.expected_class) res.frame_event = ubx_fp_pkg::EV_REJECT;
      end
      ubx_fp_pkg::PH_ID: begin
        if (rx_byte != cfg.expected_id) res.frame_event = ubx_fp_pkg::EV_REJECT;
      end
      ubx_fp_pkg::PH_LEN2: begin
        if (full_len != cfg.expected_length) res.frame_event = ubx_fp_pkg::EV_REJECT;
      end
      ubx_fp_pkg::PH_PAYLOAD: begin
        res.payload_valid = 1'b1;
        res.payload_data  = rx_byte;
        res.payload_index = byte_pos_r;
      end
      ubx_fp_pkg::PH_CKA: begin
        if (rx_byte != sum_a_r) res.frame_event = ubx_fp_pkg::EV_CKERR;
      end
      ubx_fp_pkg::PH_CKB: begin
        res.frame_event = (rx_byte == sum_b_r) ? ubx_fp_pkg::EV_GOOD
                                               : ubx_fp_pkg::EV_CKERR;
      end
      default: begin
        res.frame_event = ubx_fp_pkg::EV_NONE;
      end
    endcase
  end

  // State advances only when a transaction is accepted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= ubx_fp_pkg::PH_SYNC1;
      sum_a_r    <= 8'd0;
      sum_b_r    <= 8'd0;
      decl_len_r <= 16'd0;
      byte_pos_r <= 16'd0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      sum_a_r    <= sum_a_nxt;
      sum_b_r    <= sum_b_nxt;
      decl_len_r <= decl_len_nxt;
      byte_pos_r <= byte_pos_nxt;
    end
  end

  // Payload bytes come only from the payload phase.
  `UBX_ASSERT_NOW(a_payload_phase, clk, rst_n, res.payload_valid, phase_r == ubx_fp_pkg::PH_PAYLOAD, "payload byte outside payload phase")
  // A good frame is only reported on the second checksum byte.
  `UBX_ASSERT_NOW(a_good_on_ckb, clk, rst_n, res.frame_event == ubx_fp_pkg::EV_GOOD, phase_r == ubx_fp_pkg::PH_CKB, "good event outside second checksum byte")
  // After the second checksum byte the parser hunts for sync again.
  `UBX_ASSERT_NEXT(a_ckb_to_sync, clk, rst_n, accept && (phase_r == ubx_fp_pkg::PH_CKB), phase_r == ubx_fp_pkg::PH_SYNC1, "no return to sync hunting after frame end")
  // Each accepted payload byte advances the position by one.
  `UBX_ASSERT_NEXT(a_pos_step, clk, rst_n, accept && (phase_r == ubx_fp_pkg::PH_PAYLOAD), byte_pos_r == 16'($past(byte_pos_r) + 16'd1), "payload position did not advance")

endmodule

`default_nettype wire

// File: src/ubx_fp_obuf.sv
// Output register with a skid stage for the UBX frame parser result channel.
// Depends on ubx_fp_pkg and ubx_frame_parser_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "ubx_frame_parser_defines.svh"

module ubx_fp_obuf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire ubx_fp_pkg::result_t res_in,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ubx_fp_pkg::result_t    res_out
);

  logic                out_valid_r, out_valid_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  ubx_fp_pkg::result_t out_res_r, out_res_nxt;
  ubx_fp_pkg::result_t skid_res_r, skid_res_nxt;
  logic                out_free;

  // The output register can load when it is empty or being taken this cycle.
  assign out_free = !out_valid_r || !out_stall;

  // Fill and drain of the two stages.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_res_nxt    = skid_res_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (push) begin
        out_res_nxt   = res_in;
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (push) begin
      skid_res_nxt   = res_in;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign res_out   = out_res_r;

  // A held skid entry always sits behind a full output register.
  `UBX_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r, "skid entry without output entry")
  // The skid stage only fills when the output register is held.
  `UBX_ASSERT_NEXT(a_skid_fill, clk, rst_n, !skid_valid_r && !(out_valid_r && out_stall), !skid_valid_r, "skid filled while output was free")

endmodule

`default_nettype wire

// File: src/ubx_frame_parser.sv
// UBX frame parser, one received byte per transaction on the input channel.
//
// Input channel: in_valid / in_stall / in_rx_byte. A byte is taken at a rising
// edge where in_valid is high and in_stall is low.
// Result channel: out_valid / out_stall plus the payload fields and the frame
// event. Every accepted byte yields exactly one result transaction.
// Configuration: cfg_we / cfg_index / cfg_wdata set the expected class, id and
// payload length; write them only while the parser is idle.
// Each result is registered in the output register, or in the skid stage.
// Throughput: one byte per cycle while in_stall is low; the parse state and
// the 8-bit checksum update sit between the input port and the output register.
// Stall: when the receiver stalls, one more result lands in a skid stage and
// in_stall rises the next cycle; in_stall comes straight from a flop.
// Reset (synchronous, active low): parser hunts for the first sync byte,
// checksum and counters clear, registers return to class 1, id 7, length 92,
// and both output stages empty.
// Depends on ubx_fp_pkg, ubx_fp_cfg, ubx_fp_fsm and ubx_fp_obuf.
`timescale 1ns / 1ps
`default_nettype none

module ubx_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_payload_valid,
  output logic [7:0]       out_payload_data,
  output logic [15:0]      out_payload_index,
  output logic [1:0]       out_frame_event,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  ubx_fp_pkg::cfg_t    cfg;
  ubx_fp_pkg::result_t res_comb;
  ubx_fp_pkg::result_t res_out;
  logic                accept;

  // Input transaction handshake.
  assign accept = in_valid && !in_stall;

  ubx_fp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ubx_fp_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .cfg     (cfg),
    .res     (res_comb)
  );

  ubx_fp_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .res_in    (res_comb),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_out)
  );

  // Unpack the result onto the output ports.
  assign out_payload_valid = res_out.payload_valid;
  assign out_payload_data  = res_out.payload_data;
  assign out_payload_index = res_out.payload_index;
  assign out_frame_event   = res_out.frame_event;

endmodule

`default_nettype wire

// File: test/ubx_fp_checker.sv
// Scoreboard for the UBX frame parser: follows register writes, predicts one result
// per accepted byte and checks every accepted result, field by field, in order.
// Depends on ubx_fp_pkg for phases, event codes, register indexes and structs.
`timescale 1ns / 1ps

module ubx_fp_checker
  import ubx_fp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_payload_valid,
  input  logic [7:0]  out_payload_data,
  input  logic [15:0] out_payload_index,
  input  logic [1:0]  out_frame_event,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          mismatches,
  output int          outstanding
);

  // Keep the log readable when the design is badly broken.
  localparam int PRINT_LIMIT = 50;

  // Shadow copy of the registers and of the parse state.
  cfg_t        cfg;
  phase_t      phase;
  logic [7:0]  sum_a;
  logic [7:0]  sum_b;
  logic [15:0] frame_len;
  logic [15:0] taken;
  result_t     predicted[$];

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  // One step of the 8-bit Fletcher sum.
  function automatic void fold(input logic [7:0] b);
    sum_a = sum_a + b;
    sum_b = sum_b + sum_a;
  endfunction

  // Advance the shadow parser by one received byte and return the result it owes.
  function automatic result_t parse_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    case (phase)
      PH_SYNC1: if (b == SYNC_FIRST) phase = PH_SYNC2;
      // A bad second sync byte is dropped, never taken as a fresh first one.
      PH_SYNC2: phase = (b == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
      PH_CLASS: begin
        if (b != cfg.expected_class) begin
          phase = PH_SYNC1;
          r.frame_event = EV_REJECT;
        end else begin
          sum_a = b;
          sum_b = b;
          phase = PH_ID;
        end
      end
      PH_ID: begin
        if (b != cfg.expected_id) begin
          phase = PH_SYNC1;
          r.frame_event = EV_REJECT;
        end else begin
          fold(b);
          phase = PH_LEN1;
        end
      end
      PH_LEN1: begin
        frame_len = {8'h00, b};
        fold(b);
        phase = PH_LEN2;
      end
      // The length is latched here; later register writes do not touch this frame.
      PH_LEN2: begin
        frame_len[15:8] = b;
        if (frame_len != cfg.expected_length) begin
          phase = PH_SYNC1;
          r.frame_event = EV_REJECT;
        end else begin
          fold(b);
          taken = '0;
          phase = (frame_len == 16'd0) ? PH_CKA : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        r.payload_valid = 1'b1;
        r.payload_data = b;
        r.payload_index = taken;
        fold(b);
        taken = taken + 16'd1;
        if (taken >= frame_len) phase = PH_CKA;
      end
      // A wrong first checksum byte ends the frame without waiting for the second.
      PH_CKA: begin
        if (b != sum_a) begin
          phase = PH_SYNC1;
          r.frame_event = EV_CKERR;
        end else begin
          phase = PH_CKB;
        end
      end
      PH_CKB: begin
        r.frame_event = (b == sum_b) ? EV_GOOD : EV_CKERR;
        phase = PH_SYNC1;
      end
      default: phase = PH_SYNC1;
    endcase
    return r;
  endfunction

  // Count every mismatch; print one line for each of the first PRINT_LIMIT.
  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Watch both channels and the register port at every rising edge.
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      cfg.expected_class = RST_CLASS;
      cfg.expected_id = RST_ID;
      cfg.expected_length = RST_LENGTH;
      phase = PH_SYNC1;
      sum_a = '0;
      sum_b = '0;
      frame_len = '0;
      taken = '0;
      predicted.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CLASS:  cfg.expected_class = cfg_wdata[7:0];
          CFG_ID:     cfg.expected_id = cfg_wdata[7:0];
          CFG_LENGTH: cfg.expected_length = cfg_wdata;
          default: ;
        endcase
      end
      // The result of a byte taken at this edge cannot leave before the next one.
      if (out_valid && !out_stall) begin
        if (predicted.size() == 0) begin
          report_mismatch("result transaction with no byte waiting for it");
        end else begin
          want = predicted.pop_front();
          if (out_payload_valid !== want.payload_valid)
            report_mismatch($sformatf("payload_valid %b, expected %b",
                                      out_payload_valid, want.payload_valid));
          if (out_payload_data !== want.payload_data)
            report_mismatch($sformatf("payload_data %h, expected %h",
                                      out_payload_data, want.payload_data));
          if (out_payload_index !== want.payload_index)
            report_mismatch($sformatf("payload_index %0d, expected %0d",
                                      out_payload_index, want.payload_index));
          if (out_frame_event !== want.frame_event)
            report_mismatch($sformatf("frame_event %0d, expected %0d",
                                      out_frame_event, want.frame_event));
        end
      end
      if (in_valid && !in_stall) predicted.push_back(parse_byte(in_rx_byte));
    end
    outstanding = predicted.size();
  end

endmodule

// File: test/tb.sv
// Top of the UBX frame parser regression: clock, reset, register writes, byte
// stimulus and random stalls on the result side; ubx_fp_checker does the checking.
// Depends on ubx_fp_pkg, ubx_frame_parser and ubx_fp_checker.
`timescale 1ns / 1ps

module tb;
  import ubx_fp_pkg::*;

  // Register index with no register behind it.
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 500;
  localparam int MIN_PHASES = 7;
  localparam int HOLD_CYCLES = 200;
  localparam int MAX_LENGTH = 65535;

  typedef enum int {
    FR_GOOD, FR_BAD_SYNC2, FR_BAD_CLASS, FR_BAD_ID, FR_BAD_LEN,
    FR_BAD_CKA, FR_BAD_CKB, FR_CUT
  } frame_kind_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_payload_valid;
  logic [7:0]  out_payload_data;
  logic [15:0] out_payload_index;
  logic [1:0]  out_frame_event;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  int          mismatches;
  int          outstanding;

  // Testbench state; no_idle and hold_request are shared between the byte source and the result sink.
  bit          no_idle;
  bit          hold_request;
  int          sent;
  logic [7:0]  cur_class;
  logic [7:0]  cur_id;
  logic [15:0] cur_len;
  logic [7:0]  frame_bytes[$];

  ubx_frame_parser dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_payload_valid(out_payload_valid), .out_payload_data(out_payload_data),
    .out_payload_index(out_payload_index), .out_frame_event(out_frame_event),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  ubx_fp_checker scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_payload_valid(out_payload_valid), .out_payload_data(out_payload_data),
    .out_payload_index(out_payload_index), .out_frame_event(out_frame_event),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Hard stop in case the design hangs.
  initial begin
    #2_000_000;
    $display("ubx_frame_parser regression: fail");
    $finish;
  end

  // Payload and noise bytes, biased toward the extremes and the sync pattern.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return SYNC_FIRST;
      3: return SYNC_SECOND;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one byte after a random gap and hold it until the parser takes it.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  // Stop offering bytes until every predicted result has been delivered.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_CLASS:  cur_class = val[7:0];
      CFG_ID:     cur_id = val[7:0];
      CFG_LENGTH: cur_len = val;
      default: ;
    endcase
  endtask

  // Random upper bits on the byte-wide registers must be ignored.
  task automatic set_config(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len);
    wait_idle();
    write_reg(CFG_CLASS, {8'($urandom), cls});
    write_reg(CFG_ID, {8'($urandom), id});
    write_reg(CFG_LENGTH, len);
  endtask

  // Build one frame for the current registers, spoil it as asked, and send it.
  // At byte position split the source goes idle and the length register changes.
  task automatic send_frame(input frame_kind_t kind, input int split);
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [7:0]  ck_a;
    logic [7:0]  ck_b;
    logic [7:0]  b;
    logic [15:0] len;
    int          cut;
    cls = (kind == FR_BAD_CLASS) ? cur_class ^ 8'($urandom_range(1, 255)) : cur_class;
    id = (kind == FR_BAD_ID) ? cur_id ^ 8'($urandom_range(1, 255)) : cur_id;
    len = (kind == FR_BAD_LEN) ? cur_len ^ 16'($urandom_range(1, 65535)) : cur_len;
    frame_bytes.delete();
    frame_bytes.push_back(SYNC_FIRST);
    if (kind == FR_BAD_SYNC2) begin
      b = pick_byte();
      frame_bytes.push_back((b == SYNC_SECOND) ? SYNC_FIRST : b);
    end else begin
      frame_bytes.push_back(SYNC_SECOND);
    end
    frame_bytes.push_back(cls);
    frame_bytes.push_back(id);
    frame_bytes.push_back(len[7:0]);
    frame_bytes.push_back(len[15:8]);
    repeat (cur_len) frame_bytes.push_back(pick_byte());
    ck_a = '0;
    ck_b = '0;
    for (int i = 2; i < frame_bytes.size(); i++) begin
      ck_a = ck_a + frame_bytes[i];
      ck_b = ck_b + ck_a;
    end
    frame_bytes.push_back((kind == FR_BAD_CKA) ? ck_a ^ 8'($urandom_range(1, 255)) : ck_a);
    // After a bad first checksum byte the second one is sometimes left out.
    if (kind != FR_BAD_CKA || $urandom_range(0, 1) == 1)
      frame_bytes.push_back((kind == FR_BAD_CKB) ? ck_b ^ 8'($urandom_range(1, 255)) : ck_b);
    if (kind == FR_CUT) begin
      cut = $urandom_range(1, frame_bytes.size() - 1);
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end
    foreach (frame_bytes[i]) begin
      if (i == split) begin
        wait_idle();
        write_reg(CFG_LENGTH, 16'($urandom_range(1, 12)));
      end
      send_byte(frame_bytes[i]);
    end
  endtask

  // Result sink: random stalls per transaction, plus one long hold on request.
  initial begin
    int w;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      w = no_idle ? 0 : $urandom_range(0, 16);
      if (w > 0) begin
        out_stall = 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Byte source, register writes and verdict.
  initial begin
    int r;
    int frames;
    int waited;
    frame_kind_t kind;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    cfg_we = 1'b0;
    cfg_index = CFG_CLASS;
    cfg_wdata = 16'h0000;
    no_idle = 1'b0;
    hold_request = 1'b0;
    sent = 0;
    cur_class = RST_CLASS;
    cur_id = RST_ID;
    cur_len = RST_LENGTH;
    rst_n = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part with one-byte frames.
    set_config(8'hFF, 8'h00, 16'd1);
    // The byte that breaks the sync pattern is not looked at again.
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    // Wrong class, then wrong id.
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(8'hFE);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_frame(FR_GOOD, -1);
    send_frame(FR_BAD_CKA, -1);

    // Random part, one register setting per phase; every special phase always runs.
    sent = 0;
    for (int ph = 0; ph < MIN_PHASES || sent < RANDOM_ITEMS; ph++) begin
      case (ph)
        0: set_config(8'h00, 8'hFF, 16'd0);
        1: set_config(8'hFF, 8'hFF, 16'd1);
        2: set_config(8'h00, 8'h00, 16'd260);
        default: set_config(8'($urandom), 8'($urandom), 16'($urandom_range(1, 12)));
      endcase
      if (ph == 6) write_reg(CFG_SPARE, 16'($urandom));
      no_idle = (ph % 4 == 3) || (ph == 4);
      // Receiver holds off while bytes keep coming, so the input stalls.
      if (ph == 4) hold_request = 1'b1;
      // Length register rewritten while a frame is in flight.
      if (ph == 5) send_frame(FR_GOOD, 6 + $urandom_range(0, cur_len - 1));
      frames = (cur_len > 64) ? 1 : 3;
      repeat (frames) begin
        r = $urandom_range(0, 19);
        if (r == 19) begin
          repeat ($urandom_range(1, 6)) send_byte(pick_byte());
        end else begin
          kind = (r <= 11) ? FR_GOOD : frame_kind_t'(r - 11);
          send_frame(kind, -1);
        end
      end
    end

    // Largest declared length: the header is taken and a few payload bytes follow.
    set_config(cur_class, cur_id, 16'(MAX_LENGTH));
    no_idle = 1'b1;
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(cur_class);
    send_byte(cur_id);
    send_byte(8'hFF);
    send_byte(8'hFF);
    repeat (4) send_byte(pick_byte());
    no_idle = 1'b0;

    // Drain, then keep the clock running for anything unexpected.
    in_valid = 1'b0;
    waited = 0;
    while (outstanding != 0 && waited < 10000) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ubx_frame_parser regression: pass");
    end else begin
      $display("ubx_frame_parser regression: fail");
    end
    $finish;
  end

endmodule
